>>> hw/rtl/sact_pkg.sv
`default_nettype none

package sact_pkg;

    localparam int TABLE_SLOTS    = 24;
    localparam int RESERVED_SLOTS = 3;
    localparam int AMBIENT_SLOTS  = TABLE_SLOTS - RESERVED_SLOTS;

    localparam int ADDR_W  = 48;
    localparam int SIG_W   = 8;
    localparam int CNT_W   = 32;
    localparam int IDX_W   = 5;
    localparam int OUTC_W  = 2;
    localparam int HEARD_O = 5;

    localparam int SLOT_W  = $clog2(TABLE_SLOTS);
    localparam int AMB_AW  = (AMBIENT_SLOTS > 1) ? $clog2(AMBIENT_SLOTS) : 1;
    localparam int AMB_CW  = $clog2(AMBIENT_SLOTS + 1);
    localparam int HEARD_W = $clog2(TABLE_SLOTS + 1);
    localparam int SLOTD_W = SIG_W + CNT_W;

    localparam int BEACON_REGS = 3;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_BEACON_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BEACON_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BEACON_THIRD  = 2'd2;

    typedef enum logic [OUTC_W-1:0] {
        OUT_UPDATED = 2'd0,
        OUT_CLAIMED = 2'd1,
        OUT_FULL    = 2'd2
    } t_outcome;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_UPD,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

>>> hw/rtl/sact_frame_if.sv
`default_nettype none

interface sact_frame_if;
    import sact_pkg::*;

    logic                     valid;
    logic                     ready;
    logic        [ADDR_W-1:0] src_addr;
    logic signed [SIG_W-1:0]  signal_dbm;

    modport source (output valid, output src_addr, output signal_dbm, input ready);
    modport sink   (input valid, input src_addr, input signal_dbm, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/sact_result_if.sv
`default_nettype none

interface sact_result_if;
    import sact_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [IDX_W-1:0]     slot_index;
    logic [OUTC_W-1:0]    outcome;
    logic [CNT_W-1:0]     frame_count;
    logic [HEARD_O-1:0]   heard_sources;
    logic                 overflow_seen;

    modport source (output valid, output slot_index, output outcome, output frame_count,
                    output heard_sources, output overflow_seen, input ready);
    modport sink   (input valid, input slot_index, input outcome, input frame_count,
                    input heard_sources, input overflow_seen, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/sact_ram.sv
`default_nettype none

module sact_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                         i_clk,
    input  wire logic                                         i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                             i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hw/rtl/source_address_census_table_core.sv
`default_nettype none

// Channel   Direction  Handshake      Contents
// i_frame   in         valid/ready    src_addr, signal_dbm
// o_result  out        valid/ready    slot_index, outcome, frame_count,
//                                     heard_sources, overflow_seen
// i_cfg_*   in         write enable   beacon address registers 0 to 2
//
// A word is handled by scanning the ambient address memory one entry per cycle
// through its single read port, then by one read-modify-write of slot data,
// which is skipped when the table is full. One word is in work at a time; the
// next word is taken once the result sits in the output register, even if that
// result is still stalled.
// Reset is synchronous and clears all used marks and counts at once.

module source_address_census_table_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    sact_frame_if.sink                              i_frame,
    sact_result_if.source                           o_result,
    input  wire logic                               i_cfg_we,
    input  wire logic [sact_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [sact_pkg::ADDR_W-1:0]        i_cfg_data
);
    import sact_pkg::*;

    t_state                   r_state, n_state;
    logic [ADDR_W-1:0]        r_beacon [BEACON_REGS];
    logic [AMBIENT_SLOTS-1:0] r_used, n_used;
    logic [TABLE_SLOTS-1:0]   r_fvld, n_fvld;
    logic [HEARD_W-1:0]       r_heard, n_heard;
    logic                     r_full, n_full;
    logic                     r_hit, n_hit;
    logic                     r_free_vld, n_free_vld;
    logic                     r_rd_pend, n_rd_pend;
    logic [AMB_CW-1:0]        r_idx, n_idx;
    logic                     r_ovld, n_ovld;

    logic [ADDR_W-1:0]        r_addr, n_addr;
    logic [SIG_W-1:0]         r_sig, n_sig;
    logic [SLOT_W-1:0]        r_slot, n_slot;
    logic [AMB_AW-1:0]        r_rd_k, n_rd_k;
    logic [AMB_AW-1:0]        r_free_k, n_free_k;
    t_outcome                 r_outcome, n_outcome;
    logic [CNT_W-1:0]         r_count, n_count;
    logic [IDX_W-1:0]         r_o_slot, n_o_slot;
    t_outcome                 r_o_outcome, n_o_outcome;
    logic [CNT_W-1:0]         r_o_count, n_o_count;
    logic [HEARD_O-1:0]       r_o_heard, n_o_heard;
    logic                     r_o_full, n_o_full;

    logic                     b_hit;
    logic [SLOT_W-1:0]        b_slot;
    logic                     amb_we;
    logic [AMB_AW-1:0]        amb_raddr;
    logic [ADDR_W-1:0]        amb_rdata;
    logic                     fr_we;
    logic [SLOT_W-1:0]        fr_raddr;
    logic [SLOTD_W-1:0]       fr_wdata;
    logic [SLOTD_W-1:0]       fr_rdata;
    logic [CNT_W-1:0]         old_cnt;
    logic [CNT_W-1:0]         new_cnt;

    sact_ram #(.WIDTH(ADDR_W), .DEPTH(AMBIENT_SLOTS)) u_amb_ram (
        .i_clk   (i_clk),
        .i_we    (amb_we),
        .i_waddr (r_free_k),
        .i_wdata (r_addr),
        .i_raddr (amb_raddr),
        .o_rdata (amb_rdata)
    );

    sact_ram #(.WIDTH(SLOTD_W), .DEPTH(TABLE_SLOTS)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (fr_we),
        .i_waddr (r_slot),
        .i_wdata (fr_wdata),
        .i_raddr (fr_raddr),
        .o_rdata (fr_rdata)
    );

    always_comb begin
        b_hit  = 1'b0;
        b_slot = '0;
        for (int i = RESERVED_SLOTS - 1; i >= 0; i--) begin
            if (r_beacon[i] == i_frame.src_addr) begin
                b_hit  = 1'b1;
                b_slot = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_fvld      = r_fvld;
        n_heard     = r_heard;
        n_full      = r_full;
        n_hit       = r_hit;
        n_free_vld  = r_free_vld;
        n_rd_pend   = r_rd_pend;
        n_idx       = r_idx;
        n_ovld      = r_ovld;
        n_addr      = r_addr;
        n_sig       = r_sig;
        n_slot      = r_slot;
        n_rd_k      = r_rd_k;
        n_free_k    = r_free_k;
        n_outcome   = r_outcome;
        n_count     = r_count;
        n_o_slot    = r_o_slot;
        n_o_outcome = r_o_outcome;
        n_o_count   = r_o_count;
        n_o_heard   = r_o_heard;
        n_o_full    = r_o_full;
        i_frame.ready = 1'b0;
        amb_we      = 1'b0;
        amb_raddr   = r_idx[AMB_AW-1:0];
        fr_we       = 1'b0;
        fr_raddr    = r_slot;
        old_cnt     = r_fvld[r_slot] ? fr_rdata[CNT_W-1:0] : '0;
        new_cnt     = (r_outcome == OUT_CLAIMED) ? CNT_W'(1) : old_cnt + CNT_W'(1);
        fr_wdata    = {r_sig, new_cnt};

        if (r_ovld && o_result.ready) begin
            n_ovld = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                i_frame.ready = i_rst_n;
                if (i_frame.valid) begin
                    n_addr     = i_frame.src_addr;
                    n_sig      = i_frame.signal_dbm;
                    n_hit      = b_hit;
                    n_slot     = b_slot;
                    n_free_vld = 1'b0;
                    n_idx      = '0;
                    n_rd_pend  = 1'b0;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_rd_pend) begin
                    if (r_used[r_rd_k]) begin
                        if (!r_hit && (amb_rdata == r_addr)) begin
                            n_hit  = 1'b1;
                            n_slot = SLOT_W'(r_rd_k) + SLOT_W'(RESERVED_SLOTS);
                        end
                    end else if (!r_free_vld) begin
                        n_free_vld = 1'b1;
                        n_free_k   = r_rd_k;
                    end
                end
                if (r_idx != AMB_CW'(AMBIENT_SLOTS)) begin
                    n_rd_pend = 1'b1;
                    n_rd_k    = r_idx[AMB_AW-1:0];
                    n_idx     = r_idx + AMB_CW'(1);
                end else begin
                    n_rd_pend = 1'b0;
                end
                if (!r_rd_pend && (r_idx == AMB_CW'(AMBIENT_SLOTS))) begin
                    if (r_hit) begin
                        n_outcome = OUT_UPDATED;
                        n_state   = ST_READ;
                    end else if (r_free_vld) begin
                        n_outcome = OUT_CLAIMED;
                        n_slot    = SLOT_W'(r_free_k) + SLOT_W'(RESERVED_SLOTS);
                        n_state   = ST_READ;
                    end else begin
                        n_outcome = OUT_FULL;
                        n_slot    = '0;
                        n_count   = '0;
                        n_full    = 1'b1;
                        n_state   = ST_DONE;
                    end
                end
            end
            ST_READ: begin
                n_state = ST_UPD;
            end
            ST_UPD: begin
                fr_we          = 1'b1;
                n_fvld[r_slot] = 1'b1;
                n_count        = new_cnt;
                if (r_outcome == OUT_CLAIMED) begin
                    amb_we           = 1'b1;
                    n_used[r_free_k] = 1'b1;
                    n_heard          = r_heard + HEARD_W'(1);
                end else if (old_cnt == '0) begin
                    n_heard = r_heard + HEARD_W'(1);
                end else if (new_cnt == '0) begin
                    n_heard = r_heard - HEARD_W'(1);
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_ovld || o_result.ready) begin
                    n_ovld      = 1'b1;
                    n_o_slot    = IDX_W'(r_slot);
                    n_o_outcome = r_outcome;
                    n_o_count   = r_count;
                    n_o_heard   = (32'(r_heard) > 32'd31) ? HEARD_O'(31) : HEARD_O'(r_heard);
                    n_o_full    = r_full;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_used     <= '0;
            r_fvld     <= '0;
            r_heard    <= '0;
            r_full     <= 1'b0;
            r_hit      <= 1'b0;
            r_free_vld <= 1'b0;
            r_rd_pend  <= 1'b0;
            r_idx      <= '0;
            r_ovld     <= 1'b0;
            for (int i = 0; i < BEACON_REGS; i++) begin
                r_beacon[i] <= '0;
            end
        end else begin
            r_state    <= n_state;
            r_used     <= n_used;
            r_fvld     <= n_fvld;
            r_heard    <= n_heard;
            r_full     <= n_full;
            r_hit      <= n_hit;
            r_free_vld <= n_free_vld;
            r_rd_pend  <= n_rd_pend;
            r_idx      <= n_idx;
            r_ovld     <= n_ovld;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_BEACON_FIRST:  r_beacon[0] <= i_cfg_data;
                    CFG_BEACON_SECOND: r_beacon[1] <= i_cfg_data;
                    CFG_BEACON_THIRD:  r_beacon[2] <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr      <= n_addr;
        r_sig       <= n_sig;
        r_slot      <= n_slot;
        r_rd_k      <= n_rd_k;
        r_free_k    <= n_free_k;
        r_outcome   <= n_outcome;
        r_count     <= n_count;
        r_o_slot    <= n_o_slot;
        r_o_outcome <= n_o_outcome;
        r_o_count   <= n_o_count;
        r_o_heard   <= n_o_heard;
        r_o_full    <= n_o_full;
    end

    assign o_result.valid         = r_ovld;
    assign o_result.slot_index    = r_o_slot;
    assign o_result.outcome       = r_o_outcome;
    assign o_result.frame_count   = r_o_count;
    assign o_result.heard_sources = r_o_heard;
    assign o_result.overflow_seen = r_o_full;

    a_heard_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_heard) <= 32'(TABLE_SLOTS))
        else $error("heard count exceeds table size");

    a_full_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |=> r_full)
        else $error("overflow flag dropped");

    a_claim_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD && r_outcome == OUT_CLAIMED) |-> !r_used[r_free_k])
        else $error("claimed ambient slot already in use");

    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_outcome == OUT_FULL) |-> (r_full && r_count == '0))
        else $error("full outcome without flag or with nonzero count");

endmodule

`default_nettype wire
